FILE: sv/jfss_pkg.sv
// ----------------------------------------------------------------------------
// jfss_pkg
// Shared types and constants of the JPEG frame size scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jfss_pkg;

  // scan phases (a marker search never rests in a phase of its own)
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_FILL  = 3'd2;
  localparam logic [2:0] PH_LENHI = 3'd3;
  localparam logic [2:0] PH_LENLO = 3'd4;
  localparam logic [2:0] PH_FRAME = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;

  // verdict codes
  localparam logic [2:0] OC_FRAME   = 3'd0;
  localparam logic [2:0] OC_END     = 3'd1;
  localparam logic [2:0] OC_HEADER  = 3'd2;
  localparam logic [2:0] OC_LENGTH  = 3'd3;
  localparam logic [2:0] OC_EXHAUST = 3'd4;

  // configuration register indexes
  localparam logic REG_MIN_PIXELS    = 1'b0;
  localparam logic REG_BUFFER_LENGTH = 1'b1;

  // marker bytes
  localparam logic [7:0] MK_FILL  = 8'hff;
  localparam logic [7:0] MK_SOI   = 8'hd8;
  localparam logic [7:0] MK_SOS   = 8'hda;
  localparam logic [7:0] MK_EOI   = 8'hd9;
  localparam logic [7:0] MK_SOF0  = 8'hc0;
  localparam logic [7:0] MK_SOF1  = 8'hc1;
  localparam logic [7:0] MK_SOF2  = 8'hc2;
  localparam logic [7:0] MK_RST0  = 8'hd0;
  localparam logic [7:0] MK_TEM   = 8'h01;
  localparam logic [7:0] MK_STUFF = 8'h00;

  localparam logic [31:0] MIN_PIXELS_RESET = 32'd307200;
  localparam logic [32:0] MARKER_ROOM      = 33'd4;
  localparam logic [32:0] LENGTH_ROOM      = 33'd2;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] position;
    logic [7:0]  marker_code;
    logic [15:0] segment_length;
    logic [15:0] payload_left;
    logic [15:0] frame_height;
    logic [7:0]  width_high;
  } scan_state_t;

  typedef struct packed {
    logic       valid;
    logic       large_enough;
    logic [2:0] outcome;
  } verdict_t;

endpackage

`default_nettype wire

FILE: sv/jfss_in_if.sv
// ----------------------------------------------------------------------------
// jfss_in_if
// Byte channel into the scanner: one buffer byte and a start-of-buffer flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jfss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/jfss_out_if.sv
// ----------------------------------------------------------------------------
// jfss_out_if
// Verdict channel out of the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

interface jfss_out_if;
  logic       valid;
  logic       ready;
  logic       large_enough;
  logic [2:0] outcome;

  modport source (output valid, output large_enough, output outcome, input ready);
  modport sink (input valid, input large_enough, input outcome, output ready);
endinterface

`default_nettype wire

FILE: sv/jfss_step.sv
// ----------------------------------------------------------------------------
// jfss_step
// Next scan state and verdict for one buffer byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jfss_step (
  input  jfss_pkg::scan_state_t st,
  input  logic [7:0]            data_byte,
  input  logic                  first_byte,
  input  logic [31:0]           min_pixels,
  input  logic [31:0]           buffer_length,
  output jfss_pkg::scan_state_t st_next,
  output jfss_pkg::verdict_t    vd
);

  logic [31:0] pos_inc;
  logic [32:0] len33;
  logic [15:0] seg_full;
  logic [15:0] seg_m2;
  logic [31:0] len_left;
  logic [15:0] width;
  logic [31:0] area;
  logic        is_sof;
  logic        standalone;
  logic        go_search;

  assign pos_inc    = st.position + 32'd1;
  assign len33      = {1'b0, buffer_length};
  assign seg_full   = {st.segment_length[15:8], data_byte};
  assign seg_m2     = seg_full - 16'd2;
  assign len_left   = buffer_length - pos_inc;
  assign width      = {st.width_high, data_byte};
  assign area       = width * st.frame_height;
  assign is_sof     = (st.marker_code == jfss_pkg::MK_SOF0) ||
                      (st.marker_code == jfss_pkg::MK_SOF1) ||
                      (st.marker_code == jfss_pkg::MK_SOF2);
  assign standalone = (data_byte == jfss_pkg::MK_STUFF) || (data_byte == jfss_pkg::MK_TEM) ||
                      ((data_byte >= jfss_pkg::MK_RST0) && (data_byte <= jfss_pkg::MK_SOI));

  always_comb begin
    st_next         = st;
    vd.valid        = 1'b0;
    vd.large_enough = 1'b0;
    vd.outcome      = jfss_pkg::OC_FRAME;
    go_search       = 1'b0;

    if (first_byte) begin
      st_next = '0;
      if ((buffer_length < 32'd4) || (data_byte != jfss_pkg::MK_FILL)) begin
        vd.valid   = 1'b1;
        vd.outcome = jfss_pkg::OC_HEADER;
      end else begin
        st_next.position = 32'd1;
        st_next.phase    = jfss_pkg::PH_HDR1;
      end
    end else begin
      unique case (st.phase)
        jfss_pkg::PH_HDR1: begin
          if (data_byte != jfss_pkg::MK_SOI) begin
            vd.valid   = 1'b1;
            vd.outcome = jfss_pkg::OC_HEADER;
          end else begin
            st_next.position = 32'd2;
            go_search        = 1'b1;
          end
        end
        jfss_pkg::PH_FILL: begin
          st_next.position = pos_inc;
          if (data_byte == jfss_pkg::MK_FILL) begin
            if ({1'b0, pos_inc} >= len33) begin
              vd.valid   = 1'b1;
              vd.outcome = jfss_pkg::OC_EXHAUST;
            end
          end else begin
            st_next.marker_code = data_byte;
            if ((data_byte == jfss_pkg::MK_SOS) || (data_byte == jfss_pkg::MK_EOI)) begin
              vd.valid   = 1'b1;
              vd.outcome = jfss_pkg::OC_END;
            end else if (standalone) begin
              go_search = 1'b1;
            end else if (({1'b0, pos_inc} + jfss_pkg::LENGTH_ROOM) > len33) begin
              vd.valid   = 1'b1;
              vd.outcome = jfss_pkg::OC_EXHAUST;
            end else begin
              st_next.phase = jfss_pkg::PH_LENHI;
            end
          end
        end
        jfss_pkg::PH_LENHI: begin
          st_next.position       = pos_inc;
          st_next.segment_length = {data_byte, 8'h00};
          st_next.phase          = jfss_pkg::PH_LENLO;
        end
        jfss_pkg::PH_LENLO: begin
          st_next.position       = pos_inc;
          st_next.segment_length = seg_full;
          if ((seg_full < 16'd2) || (pos_inc > buffer_length) ||
              ({16'h0000, seg_m2} > len_left)) begin
            vd.valid   = 1'b1;
            vd.outcome = jfss_pkg::OC_LENGTH;
          end else if (is_sof && (seg_full >= 16'd8)) begin
            st_next.payload_left = 16'd0;
            st_next.phase        = jfss_pkg::PH_FRAME;
          end else begin
            st_next.payload_left = seg_m2;
            st_next.phase        = jfss_pkg::PH_SKIP;
            go_search            = (seg_m2 == 16'd0);
          end
        end
        jfss_pkg::PH_FRAME: begin
          // byte count in payload_left: precision, height hi/lo, width hi/lo
          st_next.position     = pos_inc;
          st_next.payload_left = st.payload_left + 16'd1;
          if (st.payload_left == 16'd1) begin
            st_next.frame_height = {data_byte, 8'h00};
          end else if (st.payload_left == 16'd2) begin
            st_next.frame_height = {st.frame_height[15:8], data_byte};
          end else if (st.payload_left == 16'd3) begin
            st_next.width_high = data_byte;
          end else if (st.payload_left >= 16'd4) begin
            vd.valid        = 1'b1;
            vd.outcome      = jfss_pkg::OC_FRAME;
            vd.large_enough = (width != 16'd0) && (st.frame_height != 16'd0) &&
                              (area >= min_pixels);
          end
        end
        jfss_pkg::PH_SKIP: begin
          st_next.position     = pos_inc;
          st_next.payload_left = st.payload_left - 16'd1;
          go_search            = (st.payload_left == 16'd1);
        end
        default: begin
        end
      endcase
    end

    // marker search: needs room for a marker and a length
    if (go_search) begin
      if (({1'b0, st_next.position} + jfss_pkg::MARKER_ROOM) > len33) begin
        vd.valid   = 1'b1;
        vd.outcome = jfss_pkg::OC_EXHAUST;
      end else begin
        st_next.phase = jfss_pkg::PH_FILL;
      end
    end

    if (vd.valid) begin
      st_next.phase = jfss_pkg::PH_IDLE;
    end
  end

endmodule

`default_nettype wire

FILE: sv/jpeg_frame_size_scanner.sv
// A verdict is registered in the result register and shown in the cycle after the byte that decides it.
// Throughput: one byte per cycle; the whole scan step, including the 16x16 area multiply and
// its compare against min_pixels, sits between the scan state and the result register.
// Input is stalled only while a verdict waits in the result register and is not taken.
// Reset (rst, synchronous): scan goes idle, min_pixels = 307200, buffer_length = 0.
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// Walks JPEG marker segments byte by byte and judges the main frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_frame_size_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data,
  jfss_in_if.sink     byte_ch,
  jfss_out_if.source  result_ch
);

  logic [31:0]           min_pixels;
  logic [31:0]           buffer_length;
  jfss_pkg::scan_state_t st;
  jfss_pkg::scan_state_t st_next;
  jfss_pkg::verdict_t    vd;
  logic                  res_valid;
  logic                  res_large;
  logic [2:0]            res_outcome;
  logic                  acc;

  assign byte_ch.ready          = !res_valid || result_ch.ready;
  assign acc                    = byte_ch.valid && byte_ch.ready;
  assign result_ch.valid        = res_valid;
  assign result_ch.large_enough = res_large;
  assign result_ch.outcome      = res_outcome;

  jfss_step u_step (
    .st            (st),
    .data_byte     (byte_ch.data_byte),
    .first_byte    (byte_ch.first_byte),
    .min_pixels    (min_pixels),
    .buffer_length (buffer_length),
    .st_next       (st_next),
    .vd            (vd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pixels    <= jfss_pkg::MIN_PIXELS_RESET;
      buffer_length <= 32'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        jfss_pkg::REG_MIN_PIXELS:    min_pixels    <= wr_data;
        jfss_pkg::REG_BUFFER_LENGTH: buffer_length <= wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (acc) begin
        st <= st_next;
      end
      if (acc && vd.valid) begin
        res_valid <= 1'b1;
      end else if (result_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && vd.valid) begin
      res_large   <= vd.large_enough;
      res_outcome <= vd.outcome;
    end
  end

  // a new verdict only follows an accepted byte
  a_res_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(acc))
    else $error("verdict without an accepted item");

  // only a found frame may be judged large
  a_large_is_frame: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_large) |-> (res_outcome == jfss_pkg::OC_FRAME))
    else $error("large_enough set on a non-frame outcome");

  // an empty payload goes straight to the marker search
  a_skip_nonempty: assert property (@(posedge clk) disable iff (rst)
    (st.phase == jfss_pkg::PH_SKIP) |-> (st.payload_left != 16'd0))
    else $error("skip phase with no payload left");

  // a verdict returns the scan to idle
  a_verdict_idle: assert property (@(posedge clk) disable iff (rst)
    (acc && vd.valid) |=> (st.phase == jfss_pkg::PH_IDLE))
    else $error("scan not idle after verdict");

endmodule

`default_nettype wire
